// File: rtl/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg - frequency counter table shared definitions
// Operation and status codes, scan item and write-back command layouts.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int AMT_W      = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int DISTINCT_W = 5;
    localparam int TOTAL_W    = 36;
    localparam int IN_W       = 72;
    localparam int OUT_W      = 112;

    localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_SAT    = '1;
    localparam logic [DISTINCT_W-1:0] DISTINCT_SAT = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_COUNT  = 3'd2,
        OP_MOST   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_SET_HIT  = 3'd1,
        CMD_FREE_HIT = 3'd2,
        CMD_NEW      = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_kind_t;

    // Scan item walking down the row of cells
    typedef struct packed {
        logic               live;
        logic               found;
        logic [COUNT_W-1:0] hit_count;
        logic               free_taken;
        logic               best_valid;
        logic [COUNT_W-1:0] best_count;
        logic [KEY_W-1:0]   best_key;
    } scan_t;

    // Write-back broadcast to all cells
    typedef struct packed {
        cmd_kind_t          kind;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

// File: rtl/fct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_cell - one table entry
// Holds one key/count pair, folds its entry into the passing scan item and
// marks itself as the hit or first free slot for the following write-back.
// ----------------------------------------------------------------------------
module fct_cell #(
    parameter int KW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [KW-1:0]   key,
    input  fct_pkg::cmd_t   cmd,
    input  fct_pkg::scan_t  scan_in,
    output fct_pkg::scan_t  scan_out
);
    import fct_pkg::*;

    logic               valid_reg, valid_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic               live_reg;
    logic [KW-1:0]      key_reg, key_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    scan_t              scan_reg, scan_next;
    logic               match;
    logic               better;

    always_comb
    begin
        match  = valid_reg && (key_reg == key);
        better = valid_reg && (!scan_in.best_valid || (count_reg > scan_in.best_count));

        scan_next = scan_in;
        if (match)
        begin
            scan_next.found     = 1'b1;
            scan_next.hit_count = count_reg;
        end
        if (!valid_reg)
            scan_next.free_taken = 1'b1;
        if (better)
        begin
            scan_next.best_valid = 1'b1;
            scan_next.best_count = count_reg;
            scan_next.best_key   = KEY_W'(key_reg);
        end

        hit_next  = hit_reg;
        free_next = free_reg;
        if (scan_in.live)
        begin
            hit_next  = match;
            free_next = !valid_reg && !scan_in.free_taken;
        end

        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        case (cmd.kind)
            CMD_SET_HIT:
            begin
                if (hit_reg)
                    count_next = cmd.count;
            end
            CMD_FREE_HIT:
            begin
                if (hit_reg)
                    valid_next = 1'b0;
            end
            CMD_NEW:
            begin
                if (free_reg)
                begin
                    valid_next = 1'b1;
                    key_next   = key;
                    count_next = cmd.count;
                end
            end
            CMD_CLEAR:
                valid_next = 1'b0;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            live_reg  <= scan_in.live;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
        if (scan_in.live)
            scan_reg <= scan_next;
    end

    always_comb
    begin
        scan_out      = scan_reg;
        scan_out.live = live_reg;
    end

endmodule

// File: rtl/fct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_ctrl - frequency counter table sequencer
// Takes an item, launches a scan down the cell row, then decides the
// write-back, updates occupancy and total, and registers the result item.
// ----------------------------------------------------------------------------
module fct_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fct_pkg::IN_W-1:0]          s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fct_pkg::OUT_W-1:0]         m_tdata,
    output logic [((KEY_BITS < 32) ? KEY_BITS : 32)-1:0] key_bus,
    output fct_pkg::cmd_t                     cmd,
    output fct_pkg::scan_t                    scan_launch,
    input  fct_pkg::scan_t                    scan_result
);
    import fct_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int SW = COUNT_W + $clog2(TABLE_DEPTH);
    localparam int OW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               launch_reg, launch_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [OW-1:0]      occ_reg, occ_next;
    logic [OP_W-1:0]    op_reg;
    logic [KW-1:0]      key_reg;
    logic [AMT_W-1:0]   amt_reg;

    logic               fire;
    logic [COUNT_W:0]   add_wide;
    logic [COUNT_W-1:0] add_count;
    logic [COUNT_W-1:0] add_inc;
    logic [COUNT_W-1:0] sub_count;
    logic               hit_gt;
    status_t            status;
    logic [KEY_W-1:0]   rkey;
    logic [COUNT_W-1:0] rcount;
    logic [DISTINCT_W-1:0] distinct;
    logic [TOTAL_W-1:0] total;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign key_bus  = key_reg;
    assign fire     = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        scan_launch      = '0;
        scan_launch.live = launch_reg;
    end

    always_comb
    begin
        add_wide  = {1'b0, scan_result.hit_count} + {1'b0, amt_reg};
        add_count = add_wide[COUNT_W] ? COUNT_MAX : add_wide[COUNT_W-1:0];
        add_inc   = add_count - scan_result.hit_count;
        sub_count = scan_result.hit_count - amt_reg;
        hit_gt    = scan_result.hit_count > amt_reg;

        cmd.kind  = CMD_NONE;
        cmd.count = add_count;
        status    = ST_OK;
        rkey      = KEY_W'(key_reg);
        rcount    = '0;
        sum_next  = sum_reg;
        occ_next  = occ_reg;

        case (op_t'(op_reg))
            OP_ADD:
            begin
                if (scan_result.found)
                begin
                    cmd.kind  = CMD_SET_HIT;
                    cmd.count = add_count;
                    rcount    = add_count;
                    sum_next  = sum_reg + SW'(add_inc);
                end
                else if (scan_result.free_taken)
                begin
                    cmd.kind  = CMD_NEW;
                    cmd.count = amt_reg;
                    rcount    = amt_reg;
                    sum_next  = sum_reg + SW'(amt_reg);
                    occ_next  = occ_reg + OW'(1);
                end
                else
                    status = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (!scan_result.found)
                    status = ST_ABSENT;
                else if (hit_gt)
                begin
                    cmd.kind  = CMD_SET_HIT;
                    cmd.count = sub_count;
                    rcount    = sub_count;
                    sum_next  = sum_reg - SW'(amt_reg);
                end
                else
                begin
                    cmd.kind = CMD_FREE_HIT;
                    sum_next = sum_reg - SW'(scan_result.hit_count);
                    occ_next = occ_reg - OW'(1);
                end
            end
            OP_COUNT:
            begin
                if (scan_result.found)
                    rcount = scan_result.hit_count;
                else
                    status = ST_ABSENT;
            end
            OP_MOST:
            begin
                if (scan_result.best_valid)
                begin
                    rkey   = scan_result.best_key;
                    rcount = scan_result.best_count;
                end
                else
                begin
                    status = ST_EMPTY;
                    rkey   = '0;
                end
            end
            OP_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
                rkey     = '0;
                sum_next = '0;
                occ_next = '0;
            end
            default:
                rkey = '0;
        endcase

        if (!fire)
            cmd.kind = CMD_NONE;

        distinct = (occ_next > OW'(DISTINCT_SAT)) ? DISTINCT_SAT : DISTINCT_W'(occ_next);
        total    = (sum_next > SW'(TOTAL_SAT)) ? TOTAL_SAT : TOTAL_W'(sum_next);

        out_data_next = OUT_W'({total, distinct, rcount, rkey, status});
    end

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    launch_next = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_result.live)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                sum_reg <= sum_next;
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= KW'(s_tdata[OP_W +: KEY_W]);
            amt_reg <= s_tdata[OP_W + KEY_W +: AMT_W];
        end
        if (fire)
            out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/frequency_counter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_counter_table - key/count table with most-frequent query
// Row of TABLE_DEPTH entry cells searched by a scan item, plus a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata: opcode (add, remove,
//   count query, most frequent query, clear), key and amount. Each item gives
//   exactly one result item on m_tvalid/m_tready/m_tdata: status, key, count,
//   number of occupied entries and total of all counts after the operation.
//   One item at a time: after acceptance a scan item walks the cell row one
//   cell per cycle; once it leaves the last cell, the sequencer writes back
//   and registers the result, and only then returns to idle to accept a new
//   item. The time per item grows with the length of the cell row.
//   The result sits in an output register; the next item is accepted and
//   scanned while it waits, and only its write-back waits for that register
//   to drain. A stalled receiver therefore lets one more item in, then holds
//   s_tready low.
//   Reset empties the table, clears the total and drops any pending result.
//   Keys compare on their low KEY_BITS bits; counts saturate at 2^32-1.
// ----------------------------------------------------------------------------
module frequency_counter_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // opcode[2:0], key[34:3], amount[66:35], zero pad
    input  logic [fct_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[1:0], result_key[33:2], result_count[65:34],
    // distinct_keys[70:66], count_total[106:71], zero pad
    output logic [fct_pkg::OUT_W-1:0] m_tdata
);
    import fct_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic [KW-1:0] key_bus;
    cmd_t          cmd;
    scan_t         chain [TABLE_DEPTH+1];

    fct_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .key_bus     (key_bus),
        .cmd         (cmd),
        .scan_launch (chain[0]),
        .scan_result (chain[TABLE_DEPTH])
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        fct_cell #(
            .KW (KW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key_bus),
            .cmd      (cmd),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1])
        );
    end

endmodule
